// ===== hdl/zbr_pkg.sv =====
// zbr_pkg: sizes, action and register codes, divider handshake types
// shared by the raster core and its iterative divider
// no dependencies
package zbr_pkg;

   localparam int WIDTH  = 128;
   localparam int HEIGHT = 128;
   localparam int CELLS  = WIDTH * HEIGHT;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int CLR_W  = ADDR_W + 1;

   // signed pixel coordinate, holds floor of a q12.4 vertex
   localparam int CW = 12;

   localparam int ACT_W = 2;
   localparam logic [ACT_W-1:0] ACT_DRAW  = 2'd0;
   localparam logic [ACT_W-1:0] ACT_READ  = 2'd1;
   localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;
   localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_FOCAL = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_AREA  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TOL   = 2'd2;

   localparam int REQ_TDATA_W = 192;
   localparam int RSP_TDATA_W = 64;

   localparam int MUL_AW = 32;
   localparam int MUL_BW = 17;
   localparam int MUL_PW = MUL_AW + MUL_BW;
   localparam int ACC_W  = 40;

   // plane_offset * focal fits 44 bits of magnitude, then 14 fraction bits
   localparam int PF_W     = 44;
   localparam int FRAC_SH  = 14;
   localparam int NUM_W    = PF_W + FRAC_SH;
   localparam int DEN_W    = 32;
   localparam int DEPTH_W  = 32;

   localparam logic signed [DEPTH_W-1:0] DEPTH_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [DEPTH_W-1:0] DEPTH_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic             start;
      logic             neg;
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic                      done;
      logic signed [DEPTH_W-1:0] quo;
   } div_rsp_type;

endpackage

// ===== hdl/zbr_div.sv =====
// zbr_div: restoring divider, one quotient bit a cycle, signed result
// saturated to 32 bits
// depends on zbr_pkg
module zbr_div (
   input  logic                 clock,
   input  logic                 reset,
   input  zbr_pkg::div_req_type div_req,
   output zbr_pkg::div_rsp_type div_rsp
);
   import zbr_pkg::*;

   localparam int CNT_W = $clog2(NUM_W);
   localparam logic [NUM_W-1:0] Q_POS_MAX = NUM_W'(64'h7FFF_FFFF);
   localparam logic [NUM_W-1:0] Q_NEG_MAX = NUM_W'(64'h8000_0000);

   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic [DEN_W-1:0]          rem_ff, rem_in;
   logic [DEN_W-1:0]          den_ff, den_in;
   logic [NUM_W-1:0]          quo_ff, quo_in;
   logic                      neg_ff, neg_in;
   logic signed [DEPTH_W-1:0] res_ff, res_in;

   logic [DEN_W:0] shifted;
   logic [DEN_W:0] trial;
   logic           fits;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      neg_in  = neg_ff;
      res_in  = res_ff;
      shifted = {rem_ff, quo_ff[NUM_W-1]};
      trial   = shifted - {1'b0, den_ff};
      fits    = shifted >= {1'b0, den_ff};
      if (busy_ff) begin
         rem_in = fits ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
         quo_in = {quo_ff[NUM_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            if (neg_ff) begin
               if (quo_in > Q_NEG_MAX) begin
                  res_in = DEPTH_MIN;
               end else begin
                  res_in = -signed'(quo_in[DEPTH_W-1:0]);
               end
            end else begin
               if (quo_in > Q_POS_MAX) begin
                  res_in = DEPTH_MAX;
               end else begin
                  res_in = signed'(quo_in[DEPTH_W-1:0]);
               end
            end
         end
      end else if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         den_in  = div_req.den;
         quo_in  = div_req.num;
         neg_in  = div_req.neg;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
      neg_ff <= neg_in;
      res_ff <= res_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quo  = res_ff;

endmodule

// ===== hdl/zbuffer_triangle_raster_core.sv =====
// zbuffer_triangle_raster_core: depth and face buffers, one shared multiplier
// under a sequencer for areas, the depth numerator and denominators, iterative divider
// depends on zbr_pkg and zbr_div
//
//   channel | dir | handshake             | payload
//   req     | in  | req_tvalid/req_tready | tdata vertices, normal, offset, address; tuser action
//   rsp     | out | rsp_tvalid/rsp_tready | tdata depth, face, pixels written, skipped
//   csr     | in  | csr_valid/csr_ready   | csr_index, csr_data
//
// read registers the address, then the buffer read, then the result; clear
// writes all 16384 cells, one cell a cycle, and the same pass runs after reset
// before the first word is taken; draw: setup products and the area test, then
// a depth check at each of the three vertices, then per box pixel the edge-area
// test and, for a pixel inside, the depth products and the divide
// one word at a time; the next is taken once the result has been taken
module zbuffer_triangle_raster_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // ax, ay, bx, by_coord, cx, cy, normal_x, normal_y, normal_z, plane_offset,
   // pixel_addr, zero fill
   input  logic [zbr_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // action
   input  logic [zbr_pkg::ACT_W-1:0]           req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // depth_value, face_id, pixels_written, skipped
   output logic [zbr_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [zbr_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [zbr_pkg::CSR_DATA_W-1:0]      csr_data
);
   import zbr_pkg::*;

   typedef enum logic [6:0] {
      ST_CLEAR = 7'b0000001,
      ST_IDLE  = 7'b0000010,
      ST_READ  = 7'b0000100,
      ST_SETUP = 7'b0001000,
      ST_VCHK  = 7'b0010000,
      ST_BOX   = 7'b0100000,
      ST_PIX   = 7'b1000000
   } state_type;

   localparam int UOP_W = 4;
   localparam logic [UOP_W-1:0] UOP_A0 = 4'd0;
   localparam logic [UOP_W-1:0] UOP_A1 = 4'd1;
   localparam logic [UOP_W-1:0] UOP_A2 = 4'd2;
   localparam logic [UOP_W-1:0] UOP_A3 = 4'd3;
   localparam logic [UOP_W-1:0] UOP_A4 = 4'd4;
   localparam logic [UOP_W-1:0] UOP_A5 = 4'd5;
   localparam logic [UOP_W-1:0] UOP_A6 = 4'd6;
   localparam logic [UOP_W-1:0] UOP_A7 = 4'd7;
   localparam logic [UOP_W-1:0] UOP_D0 = 4'd8;
   localparam logic [UOP_W-1:0] UOP_D1 = 4'd9;
   localparam logic [UOP_W-1:0] UOP_D2 = 4'd10;
   localparam logic [UOP_W-1:0] UOP_D3 = 4'd11;

   localparam logic signed [CW-1:0] XLO  = CW'(-(WIDTH / 2));
   localparam logic signed [CW-1:0] XHI  = CW'(WIDTH / 2);
   localparam logic signed [CW-1:0] XTOP = CW'(WIDTH / 2 - 1);
   localparam logic signed [CW-1:0] YLO  = CW'(-(HEIGHT / 2));
   localparam logic signed [CW-1:0] YHI  = CW'(HEIGHT / 2);
   localparam logic signed [CW-1:0] YTOP = CW'(HEIGHT / 2 - 1);
   localparam logic [14:0] WR_MAX = 15'h7FFF;

   function automatic logic signed [CW-1:0] clamp_c(input logic signed [CW-1:0] v,
                                                    input logic signed [CW-1:0] lo,
                                                    input logic signed [CW-1:0] hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic logic signed [CW-1:0] min3(input logic signed [CW-1:0] a,
                                                 input logic signed [CW-1:0] b,
                                                 input logic signed [CW-1:0] c);
      logic signed [CW-1:0] m;
      m = (b < a) ? b : a;
      return (c < m) ? c : m;
   endfunction

   function automatic logic signed [CW-1:0] max3(input logic signed [CW-1:0] a,
                                                 input logic signed [CW-1:0] b,
                                                 input logic signed [CW-1:0] c);
      logic signed [CW-1:0] m;
      m = (b > a) ? b : a;
      return (c > m) ? c : m;
   endfunction

   function automatic logic [ADDR_W-1:0] addr_of(input logic signed [CW-1:0] x,
                                                 input logic signed [CW-1:0] y);
      logic [CW-1:0] ix;
      logic [CW-1:0] iy;
      ix = x - XLO;
      iy = y - YLO;
      return ADDR_W'(ix) * ADDR_W'(HEIGHT) + ADDR_W'(iy);
   endfunction

   function automatic logic signed [ACC_W-1:0] abs_acc(input logic signed [ACC_W-1:0] v);
      return (v < 0) ? -v : v;
   endfunction

   // unpacked request fields
   logic signed [15:0]       req_ax, req_ay, req_bx, req_by_coord, req_cx, req_cy;
   logic signed [15:0]       req_normal_x, req_normal_y, req_normal_z;
   logic signed [31:0]       req_plane_offset;
   logic [ADDR_W-1:0]        req_pixel_addr;

   assign req_ax           = req_tdata[15:0];
   assign req_ay           = req_tdata[31:16];
   assign req_bx           = req_tdata[47:32];
   assign req_by_coord     = req_tdata[63:48];
   assign req_cx           = req_tdata[79:64];
   assign req_cy           = req_tdata[95:80];
   assign req_normal_x     = req_tdata[111:96];
   assign req_normal_y     = req_tdata[127:112];
   assign req_normal_z     = req_tdata[143:128];
   assign req_plane_offset = req_tdata[175:144];
   assign req_pixel_addr   = req_tdata[176 +: ADDR_W];

   state_type                 state_ff, state_in;
   logic [UOP_W-1:0]          uop_ff, uop_in;
   logic [1:0]                k_ff, k_in;
   logic [CLR_W-1:0]          clr_ff, clr_in;
   logic                      clr_rsp_ff, clr_rsp_in;
   logic [11:0]               focal_ff, focal_in;
   logic [15:0]               marea_ff, marea_in;
   logic [9:0]                tol_ff, tol_in;
   logic signed [15:0]        vx_ff [3];
   logic signed [15:0]        vx_in [3];
   logic signed [15:0]        vy_ff [3];
   logic signed [15:0]        vy_in [3];
   logic signed [15:0]        nx_ff, nx_in, ny_ff, ny_in, nz_ff, nz_in;
   logic signed [31:0]        po_ff, po_in;
   logic [ADDR_W-1:0]         raddr_ff, raddr_in;
   logic                      rok_ff, rok_in;
   logic [15:0]               face_ff, face_in;
   logic [15:0]               tri_ff, tri_in;
   logic [14:0]               written_ff, written_in;
   logic [NUM_W-1:0]          num_mag_ff, num_mag_in;
   logic                      num_neg_ff, num_neg_in;
   logic signed [DEN_W-1:0]   denz_ff, denz_in;
   logic signed [ACC_W-1:0]   whole_ff, whole_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic signed [MUL_PW-1:0]  t_ff, t_in;
   logic signed [MUL_PW-1:0]  mul_p_ff, mul_p_in;
   logic signed [DEPTH_W-1:0] sd_ff, sd_in;
   logic [15:0]               sf_ff, sf_in;
   logic                      dz_ff, dz_in;
   logic                      nearer_ff, nearer_in;
   logic [15:0]               fc_ff [2];
   logic [15:0]               fc_in [2];
   logic signed [CW-1:0]      x_ff, x_in, x1_ff, x1_in;
   logic signed [CW-1:0]      y_ff, y_in, y0_ff, y0_in, y1_ff, y1_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [DEPTH_W-1:0] rsp_depth_ff, rsp_depth_in;
   logic [15:0]               rsp_face_ff, rsp_face_in;
   logic [14:0]               rsp_written_ff, rsp_written_in;
   logic                      rsp_skip_ff, rsp_skip_in;

   logic signed [DEPTH_W-1:0] depth_mem_ff [CELLS];
   logic [15:0]               face_mem_ff [CELLS];
   logic signed [DEPTH_W-1:0] rd_depth_ff;
   logic [15:0]               rd_face_ff;

   div_req_type div_req;
   div_rsp_type div_rsp;

   zbr_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   logic signed [CW-1:0]      px [3];
   logic signed [CW-1:0]      py [3];
   logic signed [CW-1:0]      vcx, vcy, cur_x, cur_y;
   logic [ADDR_W-1:0]         mem_addr;
   logic [11:0]               focal_eff;
   logic signed [MUL_BW-1:0]  f17;
   logic signed [MUL_AW-1:0]  mul_a;
   logic signed [MUL_BW-1:0]  mul_b;
   logic [1:0]                aj;
   logic signed [MUL_BW-1:0]  qx, qy, ppx, ppy, prx, pry;
   logic signed [MUL_BW-1:0]  op1a, op1b, op2a, op2b;
   logic signed [ACC_W-1:0]   area_abs;
   logic signed [MUL_PW-1:0]  pf_abs;
   logic signed [DEN_W-1:0]   den;
   logic signed [DEPTH_W-1:0] d_val;
   logic                      pix_ok, nearer_new, adv;
   logic                      wr_en;
   logic [ADDR_W-1:0]         wr_addr;
   logic signed [DEPTH_W-1:0] wr_depth;
   logic [15:0]               wr_face;
   logic                      rsp_set, rsp_s;
   logic signed [DEPTH_W-1:0] rsp_d;
   logic [15:0]               rsp_f;
   logic [14:0]               rsp_w;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         px[i] = signed'(vx_ff[i][15:4]);
         py[i] = signed'(vy_ff[i][15:4]);
      end
      vcx       = clamp_c(px[k_ff], XLO, XTOP);
      vcy       = clamp_c(py[k_ff], YLO, YTOP);
      cur_x     = (state_ff == ST_VCHK) ? vcx : x_ff;
      cur_y     = (state_ff == ST_VCHK) ? vcy : y_ff;
      mem_addr  = (state_ff == ST_READ) ? raddr_ff : addr_of(cur_x, cur_y);
      focal_eff = (focal_ff == '0) ? 12'd1 : focal_ff;
      f17       = MUL_BW'({1'b0, focal_eff});
      pix_ok    = (x_ff != XHI) && (y_ff != YHI);

      // area operands: edge p to r against point q
      aj = (state_ff == ST_PIX) ? uop_ff[2:1] : 2'd0;
      if (state_ff == ST_PIX) begin
         qx = MUL_BW'(signed'({x_ff, 4'b0000}));
         qy = MUL_BW'(signed'({y_ff, 4'b0000}));
      end else begin
         qx = MUL_BW'(vx_ff[2]);
         qy = MUL_BW'(vy_ff[2]);
      end
      case (aj)
         2'd0: begin
            ppx = MUL_BW'(vx_ff[0]); ppy = MUL_BW'(vy_ff[0]);
            prx = MUL_BW'(vx_ff[1]); pry = MUL_BW'(vy_ff[1]);
         end
         2'd1: begin
            ppx = MUL_BW'(vx_ff[0]); ppy = MUL_BW'(vy_ff[0]);
            prx = MUL_BW'(vx_ff[2]); pry = MUL_BW'(vy_ff[2]);
         end
         default: begin
            ppx = MUL_BW'(vx_ff[1]); ppy = MUL_BW'(vy_ff[1]);
            prx = MUL_BW'(vx_ff[2]); pry = MUL_BW'(vy_ff[2]);
         end
      endcase
      op1a = prx - ppx;
      op1b = qy - ppy;
      op2a = pry - ppy;
      op2b = qx - ppx;

      area_abs = abs_acc(ACC_W'(t_ff) - ACC_W'(mul_p_ff));
      pf_abs   = (mul_p_ff < 0) ? -mul_p_ff : mul_p_ff;
      den      = DEN_W'(t_ff) + DEN_W'(mul_p_ff) + denz_ff;
      d_val    = dz_ff ? DEPTH_MAX : div_rsp.quo;
   end

   always_comb begin
      state_in       = state_ff;
      uop_in         = uop_ff;
      k_in           = k_ff;
      clr_in         = clr_ff;
      clr_rsp_in     = clr_rsp_ff;
      focal_in       = focal_ff;
      marea_in       = marea_ff;
      tol_in         = tol_ff;
      vx_in          = vx_ff;
      vy_in          = vy_ff;
      nx_in          = nx_ff;
      ny_in          = ny_ff;
      nz_in          = nz_ff;
      po_in          = po_ff;
      raddr_in       = raddr_ff;
      rok_in         = rok_ff;
      face_in        = face_ff;
      tri_in         = tri_ff;
      written_in     = written_ff;
      num_mag_in     = num_mag_ff;
      num_neg_in     = num_neg_ff;
      denz_in        = denz_ff;
      whole_in       = whole_ff;
      acc_in         = acc_ff;
      t_in           = t_ff;
      sd_in          = sd_ff;
      sf_in          = sf_ff;
      dz_in          = dz_ff;
      nearer_in      = nearer_ff;
      fc_in          = fc_ff;
      x_in           = x_ff;
      x1_in          = x1_ff;
      y_in           = y_ff;
      y0_in          = y0_ff;
      y1_in          = y1_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_depth_in   = rsp_depth_ff;
      rsp_face_in    = rsp_face_ff;
      rsp_written_in = rsp_written_ff;
      rsp_skip_in    = rsp_skip_ff;
      mul_a          = '0;
      mul_b          = '0;
      div_req        = '0;
      wr_en          = 1'b0;
      wr_addr        = mem_addr;
      wr_depth       = d_val;
      wr_face        = face_ff;
      rsp_set        = 1'b0;
      rsp_d          = '0;
      rsp_f          = '0;
      rsp_w          = '0;
      rsp_s          = 1'b0;
      nearer_new     = nearer_ff && (d_val > sd_ff);
      adv            = 1'b0;

      if (csr_valid) begin
         case (csr_index)
            CSR_FOCAL: focal_in = csr_data[11:0];
            CSR_AREA:  marea_in = csr_data;
            CSR_TOL:   tol_in   = csr_data[9:0];
            default:   ;
         endcase
      end

      case (state_ff)
         ST_CLEAR: begin
            wr_en    = 1'b1;
            wr_addr  = clr_ff[ADDR_W-1:0];
            wr_depth = '0;
            wr_face  = '0;
            clr_in   = clr_ff + 1'b1;
            if (clr_ff == CLR_W'(CELLS - 1)) begin
               state_in   = ST_IDLE;
               clr_rsp_in = 1'b0;
               rsp_set    = clr_rsp_ff;
            end
         end
         ST_IDLE: begin
            if (req_tvalid && req_tready) begin
               case (req_tuser)
                  ACT_DRAW: begin
                     vx_in[0]   = req_ax;
                     vy_in[0]   = req_ay;
                     vx_in[1]   = req_bx;
                     vy_in[1]   = req_by_coord;
                     vx_in[2]   = req_cx;
                     vy_in[2]   = req_cy;
                     nx_in      = req_normal_x;
                     ny_in      = req_normal_y;
                     nz_in      = req_normal_z;
                     po_in      = req_plane_offset;
                     face_in    = tri_ff;
                     tri_in     = tri_ff + 1'b1;
                     written_in = '0;
                     uop_in     = UOP_A0;
                     state_in   = ST_SETUP;
                  end
                  ACT_READ: begin
                     raddr_in = req_pixel_addr;
                     rok_in   = {1'b0, req_pixel_addr} < CLR_W'(CELLS);
                     uop_in   = UOP_A0;
                     state_in = ST_READ;
                  end
                  ACT_CLEAR: begin
                     tri_in     = '0;
                     clr_in     = '0;
                     clr_rsp_in = 1'b1;
                     state_in   = ST_CLEAR;
                  end
                  default: rsp_set = 1'b1;
               endcase
            end
         end
         ST_READ: begin
            if (uop_ff == UOP_A0) begin
               uop_in = UOP_A1;
            end else begin
               rsp_set  = 1'b1;
               rsp_d    = rok_ff ? rd_depth_ff : '0;
               rsp_f    = rok_ff ? rd_face_ff : '0;
               state_in = ST_IDLE;
            end
         end
         ST_SETUP: begin
            case (uop_ff)
               UOP_A0: begin
                  mul_a  = po_ff;
                  mul_b  = f17;
                  uop_in = UOP_A1;
               end
               UOP_A1: begin
                  num_neg_in = mul_p_ff < 0;
                  num_mag_in = {pf_abs[PF_W-1:0], FRAC_SH'(0)};
                  mul_a      = MUL_AW'(nz_ff);
                  mul_b      = f17;
                  uop_in     = UOP_A2;
               end
               UOP_A2: begin
                  denz_in = DEN_W'(mul_p_ff);
                  mul_a   = MUL_AW'(op1a);
                  mul_b   = op1b;
                  uop_in  = UOP_A3;
               end
               UOP_A3: begin
                  t_in   = mul_p_ff;
                  mul_a  = MUL_AW'(op2a);
                  mul_b  = op2b;
                  uop_in = UOP_A4;
               end
               default: begin
                  whole_in = area_abs;
                  if (area_abs <= signed'(ACC_W'({marea_ff, 8'b0}))) begin
                     rsp_set  = 1'b1;
                     rsp_s    = 1'b1;
                     state_in = ST_IDLE;
                  end else begin
                     k_in      = 2'd0;
                     nearer_in = 1'b1;
                     uop_in    = UOP_D0;
                     state_in  = ST_VCHK;
                  end
               end
            endcase
         end
         ST_BOX: begin
            x_in     = clamp_c(min3(px[0], px[1], px[2]), XLO, XHI);
            x1_in    = clamp_c(max3(px[0], px[1], px[2]), XLO, XHI);
            y_in     = clamp_c(min3(py[0], py[1], py[2]), YLO, YHI);
            y0_in    = clamp_c(min3(py[0], py[1], py[2]), YLO, YHI);
            y1_in    = clamp_c(max3(py[0], py[1], py[2]), YLO, YHI);
            uop_in   = UOP_A0;
            state_in = ST_PIX;
         end
         ST_VCHK, ST_PIX: begin
            case (uop_ff)
               UOP_A0: begin
                  if (!pix_ok) begin
                     adv = 1'b1;
                  end else begin
                     acc_in = whole_ff;
                     mul_a  = MUL_AW'(op1a);
                     mul_b  = op1b;
                     uop_in = UOP_A1;
                  end
               end
               UOP_A1, UOP_A3, UOP_A5: begin
                  t_in   = mul_p_ff;
                  mul_a  = MUL_AW'(op2a);
                  mul_b  = op2b;
                  uop_in = uop_ff + 1'b1;
               end
               UOP_A2, UOP_A4: begin
                  acc_in = acc_ff - area_abs;
                  mul_a  = MUL_AW'(op1a);
                  mul_b  = op1b;
                  uop_in = uop_ff + 1'b1;
               end
               UOP_A6: begin
                  acc_in = acc_ff - area_abs;
                  uop_in = UOP_A7;
               end
               UOP_A7: begin
                  if (abs_acc(acc_ff) >= signed'(ACC_W'(tol_ff))) begin
                     adv = 1'b1;
                  end else begin
                     uop_in = UOP_D0;
                  end
               end
               UOP_D0: begin
                  mul_a  = MUL_AW'(nx_ff);
                  mul_b  = MUL_BW'(cur_x);
                  uop_in = UOP_D1;
               end
               UOP_D1: begin
                  t_in   = mul_p_ff;
                  sd_in  = rd_depth_ff;
                  sf_in  = rd_face_ff;
                  mul_a  = MUL_AW'(ny_ff);
                  mul_b  = MUL_BW'(cur_y);
                  uop_in = UOP_D2;
               end
               UOP_D2: begin
                  dz_in         = den == '0;
                  div_req.start = den != '0;
                  div_req.neg   = num_neg_ff ^ (den < 0);
                  div_req.num   = num_mag_ff;
                  div_req.den   = (den < 0) ? -den : den;
                  uop_in        = UOP_D3;
               end
               UOP_D3: begin
                  if (dz_ff || div_rsp.done) begin
                     if (state_ff == ST_VCHK) begin
                        nearer_in = nearer_new;
                        if (k_ff == 2'd2) begin
                           if (nearer_new && fc_ff[0] != '0 && fc_ff[0] == fc_ff[1]
                               && fc_ff[1] == sf_ff) begin
                              rsp_set  = 1'b1;
                              rsp_s    = 1'b1;
                              state_in = ST_IDLE;
                           end else begin
                              state_in = ST_BOX;
                           end
                        end else begin
                           fc_in[k_ff[0]] = sf_ff;
                           k_in           = k_ff + 1'b1;
                           uop_in         = UOP_D0;
                        end
                     end else begin
                        if (d_val < sd_ff || sd_ff == '0) begin
                           wr_en = 1'b1;
                           if (written_ff != WR_MAX) begin
                              written_in = written_ff + 1'b1;
                           end
                        end
                        adv = 1'b1;
                     end
                  end
               end
               default: uop_in = UOP_A0;
            endcase
         end
         default: state_in = ST_CLEAR;
      endcase

      // next pixel of the box, column by column
      if (adv) begin
         uop_in = UOP_A0;
         if (y_ff < y1_ff) begin
            y_in = y_ff + 1'b1;
         end else if (x_ff < x1_ff) begin
            x_in = x_ff + 1'b1;
            y_in = y0_ff;
         end else begin
            rsp_set  = 1'b1;
            rsp_w    = written_in;
            state_in = ST_IDLE;
         end
      end

      if (rsp_set) begin
         rsp_valid_in   = 1'b1;
         rsp_depth_in   = rsp_d;
         rsp_face_in    = rsp_f;
         rsp_written_in = rsp_w;
         rsp_skip_in    = rsp_s;
      end else if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      mul_p_in = MUL_PW'(mul_a) * MUL_PW'(mul_b);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         uop_ff       <= UOP_A0;
         clr_ff       <= '0;
         clr_rsp_ff   <= 1'b0;
         focal_ff     <= 12'd256;
         marea_ff     <= 16'd15;
         tol_ff       <= 10'd25;
         tri_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         uop_ff       <= uop_in;
         clr_ff       <= clr_in;
         clr_rsp_ff   <= clr_rsp_in;
         focal_ff     <= focal_in;
         marea_ff     <= marea_in;
         tol_ff       <= tol_in;
         tri_ff       <= tri_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      k_ff           <= k_in;
      vx_ff          <= vx_in;
      vy_ff          <= vy_in;
      nx_ff          <= nx_in;
      ny_ff          <= ny_in;
      nz_ff          <= nz_in;
      po_ff          <= po_in;
      raddr_ff       <= raddr_in;
      rok_ff         <= rok_in;
      face_ff        <= face_in;
      written_ff     <= written_in;
      num_mag_ff     <= num_mag_in;
      num_neg_ff     <= num_neg_in;
      denz_ff        <= denz_in;
      whole_ff       <= whole_in;
      acc_ff         <= acc_in;
      t_ff           <= t_in;
      mul_p_ff       <= mul_p_in;
      sd_ff          <= sd_in;
      sf_ff          <= sf_in;
      dz_ff          <= dz_in;
      nearer_ff      <= nearer_in;
      fc_ff          <= fc_in;
      x_ff           <= x_in;
      x1_ff          <= x1_in;
      y_ff           <= y_in;
      y0_ff          <= y0_in;
      y1_ff          <= y1_in;
      rsp_depth_ff   <= rsp_depth_in;
      rsp_face_ff    <= rsp_face_in;
      rsp_written_ff <= rsp_written_in;
      rsp_skip_ff    <= rsp_skip_in;
   end

   // depth and face buffers, one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         depth_mem_ff[wr_addr] <= wr_depth;
         face_mem_ff[wr_addr]  <= wr_face;
      end
      rd_depth_ff <= depth_mem_ff[mem_addr];
      rd_face_ff  <= face_mem_ff[mem_addr];
   end

   assign req_tready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_skip_ff, rsp_written_ff, rsp_face_ff, rsp_depth_ff};

endmodule
